/* rtl/core/pst_pkg.sv */
// Shared types and constants for the price sorted table.
// Used by pst_cell, pst_ctrl and price_sorted_table_unit; no dependencies.
package pst_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int CODE_BITS   = 16;
    localparam int PRICE_BITS  = 24;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [CODE_BITS-1:0]  code;
        logic [PRICE_BITS-1:0] price;
    } t_entry;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic             ins_en;
        logic             rot_en;
        logic             drop;
        logic [CNT_W-1:0] count;
        t_entry           new_entry;
    } t_cell_ctl;

endpackage

/* rtl/core/pst_cell.sv */
// One slot of the sorted chain: holds a code and a price, shifts toward
// the tail on insert and toward the head on rotate. Depends on pst_pkg.
module pst_cell (
    input  logic                        i_clk,
    input  logic [pst_pkg::IDX_W-1:0]   i_slot_idx,
    input  pst_pkg::t_cell_ctl          i_ctl,
    input  pst_pkg::t_entry             i_left,
    input  logic                        i_left_gt,
    input  pst_pkg::t_entry             i_right,
    input  pst_pkg::t_entry             i_head,
    output pst_pkg::t_entry             o_entry,
    output logic                        o_gt
);
    import pst_pkg::*;

    t_entry           r_entry;
    t_entry           n_entry;
    logic [CNT_W-1:0] w_idx;
    logic             w_beyond;
    logic             w_tail;

    assign w_idx    = CNT_W'(i_slot_idx);
    assign w_beyond = (w_idx >= i_ctl.count);
    assign w_tail   = ((w_idx + 1'b1) == i_ctl.count);

    // Slot lies at or after the insert position
    assign o_gt    = w_beyond || (r_entry.price > i_ctl.new_entry.price);
    assign o_entry = r_entry;

    // Select next slot contents
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins_en) begin
            if (o_gt) begin
                n_entry = i_left_gt ? i_left : i_ctl.new_entry;
            end
        end else if (i_ctl.rot_en) begin
            n_entry = (w_tail && !i_ctl.drop) ? i_head : i_right;
        end
    end

    // Hold payload; no reset needed
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

/* rtl/core/pst_ctrl.sv */
// Sequencer for the price sorted table: request decode, head-of-chain scan,
// fill count and result registers. Depends on pst_pkg.
module pst_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_command,
    input  logic [pst_pkg::CODE_BITS-1:0] i_item_code,
    input  logic [pst_pkg::PRICE_BITS-1:0] i_price_cents,
    input  logic [pst_pkg::PRICE_BITS-1:0] i_range_low,
    input  logic [pst_pkg::PRICE_BITS-1:0] i_range_high,
    input  pst_pkg::t_entry               i_head,
    output pst_pkg::t_cell_ctl            o_ctl,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic [pst_pkg::CODE_BITS-1:0] o_out_code,
    output logic [pst_pkg::PRICE_BITS-1:0] o_out_price,
    output logic                          o_last
);
    import pst_pkg::*;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_steps, n_steps;
    t_cmd                  r_op, n_op;
    logic [CODE_BITS-1:0]  r_code, n_code;
    logic [PRICE_BITS-1:0] r_lo, n_lo;
    logic [PRICE_BITS-1:0] r_hi, n_hi;
    t_entry                r_buf, n_buf;
    logic                  r_buf_vld, n_buf_vld;
    logic                  r_found, n_found;
    logic                  r_valid, n_valid;
    t_status               r_status, n_status;
    logic [CODE_BITS-1:0]  r_out_code, n_out_code;
    logic [PRICE_BITS-1:0] r_out_price, n_out_price;
    logic                  r_last, n_last;

    logic                  w_accept;
    t_cmd                  w_cmd;
    logic                  w_full;
    logic                  w_hit;
    logic                  w_match;
    logic                  w_drop;
    logic                  w_ins;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_cmd    = t_cmd'(i_command);
    assign w_full   = (r_count == CNT_W'(TABLE_DEPTH));
    assign w_hit    = (i_head.price >= r_lo) && (i_head.price <= r_hi);
    assign w_match  = !r_found && (i_head.code == r_code);
    assign w_drop   = (r_state == S_SCAN) && (r_op == CMD_REMOVE) && w_match;
    assign w_ins    = w_accept && (w_cmd == CMD_INSERT) && !w_full;

    // Drive the cell chain
    always_comb begin
        o_ctl.ins_en          = w_ins;
        o_ctl.rot_en          = (r_state == S_SCAN);
        o_ctl.drop            = w_drop;
        o_ctl.count           = r_count;
        o_ctl.new_entry.code  = i_item_code;
        o_ctl.new_entry.price = i_price_cents;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (w_cmd == CMD_REMOVE || w_cmd == CMD_QUERY)
                        && r_count != '0) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_steps == CNT_W'(1)) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and results
    always_comb begin
        n_count     = r_count;
        n_steps     = r_steps;
        n_op        = r_op;
        n_code      = r_code;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_buf       = r_buf;
        n_buf_vld   = r_buf_vld;
        n_found     = r_found;
        n_valid     = 1'b0;
        n_status    = ST_OK;
        n_out_code  = r_out_code;
        n_out_price = r_out_price;
        n_last      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    // latch the request for a scan
                    n_op      = w_cmd;
                    n_code    = i_item_code;
                    n_lo      = i_range_low;
                    n_hi      = i_range_high;
                    n_steps   = r_count;
                    n_found   = 1'b0;
                    n_buf_vld = 1'b0;
                    unique case (w_cmd)
                        CMD_INSERT: begin
                            n_valid     = 1'b1;
                            n_status    = w_full ? ST_FULL : ST_OK;
                            n_out_code  = i_item_code;
                            n_out_price = i_price_cents;
                            n_last      = 1'b1;
                            if (!w_full) begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        CMD_REMOVE, CMD_QUERY: begin
                            if (r_count == '0) begin
                                n_valid     = 1'b1;
                                n_status    = ST_NOT_FOUND;
                                n_out_code  = '0;
                                n_out_price = '0;
                                n_last      = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_steps = r_steps - 1'b1;
                if (w_drop) begin
                    // take the head out and report it
                    n_found     = 1'b1;
                    n_count     = r_count - 1'b1;
                    n_valid     = 1'b1;
                    n_status    = ST_OK;
                    n_out_code  = i_head.code;
                    n_out_price = i_head.price;
                    n_last      = 1'b1;
                end else if (r_op == CMD_QUERY && w_hit) begin
                    // release the held match, hold the new one
                    if (r_buf_vld) begin
                        n_valid     = 1'b1;
                        n_status    = ST_OK;
                        n_out_code  = r_buf.code;
                        n_out_price = r_buf.price;
                    end
                    n_buf     = i_head;
                    n_buf_vld = 1'b1;
                end
            end
            S_FLUSH: begin
                if (r_op == CMD_QUERY && r_buf_vld) begin
                    n_valid     = 1'b1;
                    n_status    = ST_OK;
                    n_out_code  = r_buf.code;
                    n_out_price = r_buf.price;
                    n_last      = 1'b1;
                end else if (r_op == CMD_QUERY || !r_found) begin
                    n_valid     = 1'b1;
                    n_status    = ST_NOT_FOUND;
                    n_out_code  = '0;
                    n_out_price = '0;
                    n_last      = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_steps   <= '0;
            r_buf_vld <= 1'b0;
            r_found   <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_steps   <= n_steps;
            r_buf_vld <= n_buf_vld;
            r_found   <= n_found;
            r_valid   <= n_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_code      <= n_code;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_buf       <= n_buf;
        r_status    <= n_status;
        r_out_code  <= n_out_code;
        r_out_price <= n_out_price;
        r_last      <= n_last;
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_out_code  = r_out_code;
    assign o_out_price = r_out_price;
    assign o_last      = r_last;

endmodule

/* rtl/core/price_sorted_table_unit.sv */
// Price sorted table: a chain of TABLE_DEPTH cells kept in ascending price.
// Insert: shifts the chain in the accept cycle; result in the cycle after, busy is not raised.
// Remove / query: rotate one slot per cycle through the head, then flush; busy is held through
//   the scan and the flush state; empty table: result in the cycle after, no busy.
// Results appear for one cycle on o_valid and cannot be stalled.
// Synchronous active-low reset empties the table; slot contents are not cleared.
module price_sorted_table_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_command,
    input  logic [pst_pkg::CODE_BITS-1:0]   i_item_code,
    input  logic [pst_pkg::PRICE_BITS-1:0]  i_price_cents,
    input  logic [pst_pkg::PRICE_BITS-1:0]  i_range_low,
    input  logic [pst_pkg::PRICE_BITS-1:0]  i_range_high,
    output logic                            o_valid,
    output logic [1:0]                      o_status,
    output logic [pst_pkg::CODE_BITS-1:0]   o_out_code,
    output logic [pst_pkg::PRICE_BITS-1:0]  o_out_price,
    output logic                            o_last
);
    import pst_pkg::*;

    t_cell_ctl w_ctl;
    t_entry    w_entry [TABLE_DEPTH];
    logic      w_gt    [TABLE_DEPTH];

    // Sequencer
    pst_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_item_code  (i_item_code),
        .i_price_cents(i_price_cents),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .i_head       (w_entry[0]),
        .o_ctl        (w_ctl),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_out_code   (o_out_code),
        .o_out_price  (o_out_price),
        .o_last       (o_last)
    );

    // Cell chain
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        t_entry w_left;
        logic   w_left_gt;
        t_entry w_right;

        if (g == 0) begin : g_first
            assign w_left    = w_ctl.new_entry;
            assign w_left_gt = 1'b0;
        end else begin : g_mid
            assign w_left    = w_entry[g-1];
            assign w_left_gt = w_gt[g-1];
        end

        if (g == TABLE_DEPTH - 1) begin : g_end
            assign w_right = w_entry[0];
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end

        pst_cell u_cell (
            .i_clk     (i_clk),
            .i_slot_idx(IDX_W'(g)),
            .i_ctl     (w_ctl),
            .i_left    (w_left),
            .i_left_gt (w_left_gt),
            .i_right   (w_right),
            .i_head    (w_entry[0]),
            .o_entry   (w_entry[g]),
            .o_gt      (w_gt[g])
        );
    end

    // Fill count stays within the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.count <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // Insert and rotate never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctl.ins_en && w_ctl.rot_en))
        else $error("insert during rotation");

    // A drop happens only while the chain rotates
    a_drop_rot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.drop |-> w_ctl.rot_en)
        else $error("drop outside rotation");

    // An accepted insert into a non-full table grows the count by one
    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins_en |=> (w_ctl.count == $past(w_ctl.count) + 1'b1))
        else $error("insert did not grow the table");

endmodule
